// ===== rtl/omrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omrd_pkg
// Shared types, constants and helper functions of the mode 01 reply decoder.
// ----------------------------------------------------------------------------
package omrd_pkg;

    // Byte limit of one reply and the width of the counter that reaches it.
    localparam int MAX_BYTES   = 64;
    localparam int BYTE_CNT_W  = $clog2(MAX_BYTES + 1);

    localparam logic [7:0] MODE01_REPLY = 8'h41;
    localparam logic [7:0] CHAR_QMARK   = 8'h3F;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] PID_RESET    = 8'h0C;

    // Parameter numbers with a decoding.
    localparam logic [7:0] PID_COOLANT  = 8'h05;
    localparam logic [7:0] PID_MAP      = 8'h0B;
    localparam logic [7:0] PID_RPM      = 8'h0C;
    localparam logic [7:0] PID_SPEED    = 8'h0D;
    localparam logic [7:0] PID_IAT      = 8'h0F;
    localparam logic [7:0] PID_MAF      = 8'h10;
    localparam logic [7:0] PID_THROTTLE = 8'h11;
    localparam logic [7:0] PID_FUEL     = 8'h2F;

    localparam logic [8:0] TEMP_OFFSET  = 9'd40;

    // ceil(2^27 / 25): R*256/100 = (R*64)/25 = (R * M) >> 21, exact for 16-bit R.
    localparam logic [22:0] MAF_RECIP = 23'd5368710;
    // 25600 * ceil(2^31 / 255): A*25600/255 = (A * K) >> 31, exact for 8-bit A.
    localparam logic [37:0] PCT_RECIP = 38'd215590528000;

    localparam int N_ERR_TEXT = 4;

    // Error texts, left aligned and padded with spaces; the padding is never reached.
    localparam logic [N_ERR_TEXT-1:0][71:0] ERR_TEXT = {
        "BUS ERROR", "UNABLE   ", "CAN ERROR", "NO DATA  "
    };
    localparam logic [N_ERR_TEXT-1:0][3:0] ERR_LEN = {4'd9, 4'd6, 4'd9, 4'd7};

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_ERR_TEXT  = 3'd2,
        ST_NO_HEADER = 3'd3,
        ST_SHORT     = 3'd4,
        ST_NO_DECODE = 3'd5
    } t_status;

    // What the scanner hands to the decoder at the end of a reply.
    typedef struct packed {
        logic        any_content;
        logic        error_seen;
        logic        header_found;
        logic [1:0]  data_count;
        logic [15:0] data_bytes;
    } t_snap;

    function automatic logic [7:0] err_char(input logic [1:0] k, input logic [3:0] pos);
        logic [6:0] base;
        base = 7'(8 * (8 - int'(pos)));
        return ERR_TEXT[k][base +: 8];
    endfunction

    // Bit 4 flags a hex digit, bits 3..0 hold its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/omrd_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omrd_scan
// Input register and per-character reply scanner: error text matching, hex
// byte assembly, header search and data byte capture, with an end-of-reply
// snapshot register.
// ----------------------------------------------------------------------------
module omrd_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_reply_char,
    input  logic            i_end_of_reply,
    input  logic [7:0]      i_pid,
    input  logic            i_snap_take,
    output logic            o_snap_valid,
    output omrd_pkg::t_snap o_snap
);
    import omrd_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_char;
    logic                  r_in_eop;

    logic [3:0]            r_mpos [N_ERR_TEXT];
    logic [3:0]            n_mpos [N_ERR_TEXT];
    logic                  r_hn_v, n_hn_v;
    logic [3:0]            r_hn, n_hn;
    logic [BYTE_CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic                  r_prev_v, n_prev_v;
    logic [7:0]            r_prev, n_prev;
    logic                  r_hdr, n_hdr;
    logic [1:0]            r_dcount, n_dcount;
    logic [15:0]           r_data, n_data;
    logic                  r_ended, n_ended;
    logic                  r_err, n_err;
    logic                  r_any, n_any;

    logic                  r_snap_valid;
    t_snap                 r_snap, n_snap;

    logic                  snap_free;
    logic                  in_take;
    logic                  in_load;

    // A held character leaves the input register unless it ends a reply and
    // the snapshot register is still occupied.
    assign snap_free  = !r_snap_valid || i_snap_take;
    assign in_take    = r_in_valid && (!r_in_eop || snap_free);
    assign o_in_stall = r_in_valid && !in_take;
    assign in_load    = i_in_valid && !o_in_stall;

    always_comb begin : p_next
        logic [3:0] pos;
        logic [4:0] nib;
        logic [7:0] b;
        pos        = 4'd0;
        nib        = hex_nibble(r_in_char);
        b          = {r_hn, nib[3:0]};
        n_mpos     = r_mpos;
        n_hn_v     = r_hn_v;
        n_hn       = r_hn;
        n_byte_cnt = r_byte_cnt;
        n_prev_v   = r_prev_v;
        n_prev     = r_prev;
        n_hdr      = r_hdr;
        n_dcount   = r_dcount;
        n_data     = r_data;
        n_ended    = r_ended;
        n_err      = r_err;
        n_any      = r_any;
        if (in_take && !r_ended) begin
            if (r_in_char == CHAR_NUL) begin
                n_ended = 1'b1;
            end else begin
                n_any = 1'b1;
                if (r_in_char == CHAR_QMARK) begin
                    n_err = 1'b1;
                end
                for (int k = 0; k < N_ERR_TEXT; k++) begin
                    pos = r_mpos[k];
                    if (r_in_char == err_char(2'(k), pos)) begin
                        pos = pos + 4'd1;
                    end else if (r_in_char == err_char(2'(k), 4'd0)) begin
                        pos = 4'd1;
                    end else begin
                        pos = 4'd0;
                    end
                    if (pos >= ERR_LEN[k]) begin
                        n_err = 1'b1;
                        pos   = 4'd0;
                    end
                    n_mpos[k] = pos;
                end
                if (r_byte_cnt < BYTE_CNT_W'(MAX_BYTES) && nib[4]) begin
                    if (!r_hn_v) begin
                        n_hn_v = 1'b1;
                        n_hn   = nib[3:0];
                    end else begin
                        n_hn_v     = 1'b0;
                        n_hn       = 4'd0;
                        n_byte_cnt = r_byte_cnt + BYTE_CNT_W'(1);
                        if (!r_hdr) begin
                            if (r_prev_v && r_prev == MODE01_REPLY && b == i_pid) begin
                                n_hdr    = 1'b1;
                                n_dcount = 2'd0;
                            end else begin
                                n_prev_v = 1'b1;
                                n_prev   = b;
                            end
                        end else if (r_dcount < 2'd2) begin
                            if (r_dcount == 2'd0) begin
                                n_data = {b, 8'h00};
                            end else begin
                                n_data = {r_data[15:8], b};
                            end
                            n_dcount = r_dcount + 2'd1;
                        end
                    end
                end
            end
        end

        n_snap = '{any_content:  n_any,
                   error_seen:   n_err,
                   header_found: n_hdr,
                   data_count:   n_dcount,
                   data_bytes:   n_data};

        // The last character of a reply leaves the scanner clear for the next one.
        if (in_take && r_in_eop) begin
            for (int k = 0; k < N_ERR_TEXT; k++) begin
                n_mpos[k] = 4'd0;
            end
            n_hn_v     = 1'b0;
            n_hn       = 4'd0;
            n_byte_cnt = '0;
            n_prev_v   = 1'b0;
            n_prev     = 8'h00;
            n_hdr      = 1'b0;
            n_dcount   = 2'd0;
            n_data     = 16'h0000;
            n_ended    = 1'b0;
            n_err      = 1'b0;
            n_any      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (in_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_char <= i_reply_char;
            r_in_eop  <= i_end_of_reply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_ERR_TEXT; k++) begin
                r_mpos[k] <= 4'd0;
            end
            r_hn_v     <= 1'b0;
            r_hn       <= 4'd0;
            r_byte_cnt <= '0;
            r_prev_v   <= 1'b0;
            r_prev     <= 8'h00;
            r_hdr      <= 1'b0;
            r_dcount   <= 2'd0;
            r_data     <= 16'h0000;
            r_ended    <= 1'b0;
            r_err      <= 1'b0;
            r_any      <= 1'b0;
        end else begin
            r_mpos     <= n_mpos;
            r_hn_v     <= n_hn_v;
            r_hn       <= n_hn;
            r_byte_cnt <= n_byte_cnt;
            r_prev_v   <= n_prev_v;
            r_prev     <= n_prev;
            r_hdr      <= n_hdr;
            r_dcount   <= n_dcount;
            r_data     <= n_data;
            r_ended    <= n_ended;
            r_err      <= n_err;
            r_any      <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (in_take && r_in_eop) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_take) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && r_in_eop) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    a_byte_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_cnt <= BYTE_CNT_W'(MAX_BYTES))
        else $error("byte count passed the byte limit");

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_valid && !i_snap_take |=> r_snap_valid && $stable(r_snap))
        else $error("pending reply snapshot was lost or changed");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && r_in_eop |=> r_byte_cnt == '0 && !r_any && !r_hdr && !r_ended)
        else $error("scanner state not cleared after the end of a reply");

endmodule

// ===== rtl/omrd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omrd_decode
// Per-PID decoding of the captured data bytes into a Q8 value and a status,
// with the result register toward the output channel.
// ----------------------------------------------------------------------------
module omrd_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_snap_valid,
    input  omrd_pkg::t_snap    i_snap,
    input  logic [7:0]         i_pid,
    output logic               o_snap_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [22:0] o_value_q8,
    output logic [7:0]         o_data_a,
    output logic [7:0]         o_data_b
);
    import omrd_pkg::*;

    logic               r_out_valid;
    t_status            r_status, n_status;
    logic signed [22:0] r_value, n_value;
    logic [7:0]         r_data_a, n_data_a;
    logic [7:0]         r_data_b, n_data_b;

    logic               out_free;
    logic [7:0]         a;
    logic [15:0]        r16;
    logic [38:0]        maf_prod;
    logic [45:0]        pct_prod;
    logic [8:0]         temp;
    logic [1:0]         need;
    logic               known;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_snap_take = i_snap_valid && out_free;

    assign a   = i_snap.data_bytes[15:8];
    assign r16 = i_snap.data_bytes;

    // Divisions by 100 and 255 are done as multiplications by scaled reciprocals.
    assign maf_prod = 39'(r16) * 39'(MAF_RECIP);
    assign pct_prod = 46'(a) * 46'(PCT_RECIP);
    assign temp     = {1'b0, a} - TEMP_OFFSET;

    always_comb begin
        need  = 2'd1;
        known = 1'b1;
        case (i_pid)
            PID_RPM, PID_MAF: begin
                need = 2'd2;
            end
            PID_SPEED, PID_MAP, PID_COOLANT, PID_IAT, PID_THROTTLE, PID_FUEL: begin
                need = 2'd1;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_status = ST_OK;
        n_value  = '0;
        n_data_a = 8'h00;
        n_data_b = 8'h00;
        if (!i_snap.any_content) begin
            n_status = ST_EMPTY;
        end else if (i_snap.error_seen) begin
            n_status = ST_ERR_TEXT;
        end else if (!i_snap.header_found) begin
            n_status = ST_NO_HEADER;
        end else begin
            if (i_snap.data_count >= 2'd1) begin
                n_data_a = a;
            end
            if (i_snap.data_count >= 2'd2) begin
                n_data_b = i_snap.data_bytes[7:0];
            end
            if (!known) begin
                n_status = ST_NO_DECODE;
            end else if (i_snap.data_count < need) begin
                n_status = ST_SHORT;
            end else begin
                case (i_pid)
                    PID_RPM: begin
                        n_value = {1'b0, r16, 6'b000000};
                    end
                    PID_MAF: begin
                        n_value = {5'b00000, maf_prod[38:21]};
                    end
                    PID_COOLANT, PID_IAT: begin
                        n_value = {{6{temp[8]}}, temp, 8'h00};
                    end
                    PID_THROTTLE, PID_FUEL: begin
                        n_value = {8'h00, pct_prod[45:31]};
                    end
                    default: begin
                        n_value = {7'b0000000, a, 8'h00};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_snap_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_data_a <= n_data_a;
            r_data_b <= n_data_b;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_q8  = r_value;
    assign o_data_a    = r_data_a;
    assign o_data_b    = r_data_b;

endmodule

// ===== rtl/obd_mode01_reply_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_mode01_reply_decoder
// Decodes the text reply of an OBD-II adapter to a mode 01 request into a
// Q8 fixed-point value, a status and the two raw data bytes.
// ----------------------------------------------------------------------------
// One reply character can be taken in every clock cycle. While results wait
// on a stalled output, two finished replies are held, one in the decoder's
// result register and one in the scanner's snapshot register; the character
// that ends a third reply then waits in the input register and stalls the
// input until the output moves again. A reply ends with the character that
// has end_of_reply set, and that reply's result passes in turn through the
// input register, the scanner's snapshot register and the decoder's result
// register before it reaches the output. Write requested_pid only while
// no character and no result is in flight.
// ----------------------------------------------------------------------------
module obd_mode01_reply_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_reply_char,
    input  logic               i_end_of_reply,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [22:0] o_value_q8,
    output logic [7:0]         o_data_a,
    output logic [7:0]         o_data_b
);
    import omrd_pkg::*;

    logic [7:0] r_pid;
    logic       snap_valid;
    logic       snap_take;
    t_snap      snap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid <= PID_RESET;
        end else if (i_cfg_wr_en) begin
            r_pid <= i_cfg_wr_data;
        end
    end

    omrd_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_reply_char   (i_reply_char),
        .i_end_of_reply (i_end_of_reply),
        .i_pid          (r_pid),
        .i_snap_take    (snap_take),
        .o_snap_valid   (snap_valid),
        .o_snap         (snap)
    );

    omrd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .i_pid        (r_pid),
        .o_snap_take  (snap_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_value_q8   (o_value_q8),
        .o_data_a     (o_data_a),
        .o_data_b     (o_data_b)
    );

endmodule

// ===== bench/obd_mode01_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_mode01_reply_checker
// Watches both channels and the register port of the mode 01 reply decoder.
// It predicts each reply result from the accepted characters and compares
// the delivered results in order, counting every failure it finds.
// ----------------------------------------------------------------------------
module obd_mode01_reply_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_reply_char,
    input  logic               i_end_of_reply,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_status,
    input  logic signed [22:0] i_value_q8,
    input  logic [7:0]         i_data_a,
    input  logic [7:0]         i_data_b,
    output int                 o_fail_count,
    output int                 o_pending
);

    import omrd_pkg::*;

    typedef struct packed {
        t_status            status;
        logic signed [22:0] value;
        logic [7:0]         data_a;
        logic [7:0]         data_b;
    } t_reply_result;

    logic [7:0]    pid;
    logic [3:0]    word_pos [4];
    logic [4:0]    pend_nibble;
    int            byte_cnt;
    logic [8:0]    last_byte;
    logic          hdr_found;
    logic [1:0]    data_cnt;
    logic [15:0]   data_word;
    logic          nul_seen;
    logic          err_seen;
    logic          got_content;
    t_reply_result results_q [$];
    int            fail_cnt = 0;

    function automatic string alarm_word(input int k);
        case (k)
            0:       return "NO DATA";
            1:       return "CAN ERROR";
            2:       return "UNABLE";
            default: return "BUS ERROR";
        endcase
    endfunction

    // Bit 4 set marks a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, c[3:0]};
        end
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic clear_reply_state();
        for (int k = 0; k < 4; k++) begin
            word_pos[k] = 4'd0;
        end
        pend_nibble = 5'd0;
        byte_cnt    = 0;
        last_byte   = 9'd0;
        hdr_found   = 1'b0;
        data_cnt    = 2'd0;
        data_word   = 16'd0;
        nul_seen    = 1'b0;
        err_seen    = 1'b0;
        got_content = 1'b0;
    endtask

    always @(posedge i_clk) begin : track
        t_reply_result want;
        string         w;
        logic [3:0]    pos;
        logic [4:0]    nib;
        logic [7:0]    b;
        int            a_val;
        int            r_val;
        int            need;
        int            val;
        if (!i_rst_n) begin
            pid = PID_RESET;
            clear_reply_state();
            results_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("unexpected result: status %0d value %0d a %02h b %02h",
                                 i_status, i_value_q8, i_data_a, i_data_b);
                    end
                end else begin
                    want = results_q.pop_front();
                    if (i_status !== want.status || i_value_q8 !== want.value ||
                        i_data_a !== want.data_a || i_data_b !== want.data_b) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("result mismatch: expected status %0d value %0d a %02h b %02h",
                                     want.status, want.value, want.data_a, want.data_b);
                            $display("                      got status %0d value %0d a %02h b %02h",
                                     i_status, i_value_q8, i_data_a, i_data_b);
                        end
                    end
                end
            end

            if (i_cfg_wr_en) begin
                pid = i_cfg_wr_data;
            end

            if (i_in_valid && !i_in_stall) begin
                if (!nul_seen) begin
                    if (i_reply_char == CHAR_NUL) begin
                        nul_seen = 1'b1;
                    end else begin
                        got_content = 1'b1;
                        if (i_reply_char == CHAR_QMARK) begin
                            err_seen = 1'b1;
                        end
                        // A miss restarts the text at one if the character opens it.
                        for (int k = 0; k < 4; k++) begin
                            w   = alarm_word(k);
                            pos = word_pos[k];
                            if (i_reply_char == 8'(w[pos])) begin
                                pos = pos + 4'd1;
                            end else if (i_reply_char == 8'(w[0])) begin
                                pos = 4'd1;
                            end else begin
                                pos = 4'd0;
                            end
                            if (pos >= w.len()) begin
                                err_seen = 1'b1;
                                pos      = 4'd0;
                            end
                            word_pos[k] = pos;
                        end
                        nib = hex_value(i_reply_char);
                        if (byte_cnt < MAX_BYTES && nib[4]) begin
                            if (!pend_nibble[4]) begin
                                pend_nibble = nib;
                            end else begin
                                b           = {pend_nibble[3:0], nib[3:0]};
                                pend_nibble = 5'd0;
                                byte_cnt++;
                                if (!hdr_found) begin
                                    if (last_byte[8] && last_byte[7:0] == MODE01_REPLY &&
                                        b == pid) begin
                                        hdr_found = 1'b1;
                                        data_cnt  = 2'd0;
                                    end else begin
                                        last_byte = {1'b1, b};
                                    end
                                end else if (data_cnt == 2'd0) begin
                                    data_word = {b, 8'h00};
                                    data_cnt  = 2'd1;
                                end else if (data_cnt == 2'd1) begin
                                    data_word[7:0] = b;
                                    data_cnt       = 2'd2;
                                end
                            end
                        end
                    end
                end

                if (i_end_of_reply) begin
                    want.status = ST_OK;
                    want.value  = '0;
                    want.data_a = 8'd0;
                    want.data_b = 8'd0;
                    if (!got_content) begin
                        want.status = ST_EMPTY;
                    end else if (err_seen) begin
                        want.status = ST_ERR_TEXT;
                    end else if (!hdr_found) begin
                        want.status = ST_NO_HEADER;
                    end else begin
                        a_val = int'(data_word[15:8]);
                        r_val = int'(data_word);
                        case (pid)
                            PID_RPM, PID_MAF: need = 2;
                            PID_SPEED, PID_MAP, PID_COOLANT, PID_IAT,
                            PID_THROTTLE, PID_FUEL: need = 1;
                            default: need = 0;
                        endcase
                        if (need == 0) begin
                            want.status = ST_NO_DECODE;
                        end else if (data_cnt < need) begin
                            want.status = ST_SHORT;
                        end else begin
                            case (pid)
                                PID_RPM:                val = r_val * 64;
                                PID_MAF:                val = r_val * 256 / 100;
                                PID_COOLANT, PID_IAT:   val = (a_val - 40) * 256;
                                PID_THROTTLE, PID_FUEL: val = a_val * 25600 / 255;
                                default:                val = a_val * 256;
                            endcase
                            want.value = val[22:0];
                        end
                        if (data_cnt >= 2'd1) begin
                            want.data_a = data_word[15:8];
                        end
                        if (data_cnt >= 2'd2) begin
                            want.data_b = data_word[7:0];
                        end
                    end
                    results_q.push_back(want);
                    clear_reply_state();
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= results_q.size();
    end

endmodule

// ===== bench/tb_obd_mode01_reply_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_obd_mode01_reply_decoder
// Drives adapter reply text into the mode 01 reply decoder: a few directed
// replies, then random replies of every kind under changing PID settings and
// changing idle rates on both channels. A checker beside the block predicts
// and compares every result; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_obd_mode01_reply_decoder;

    import omrd_pkg::*;

    localparam int RESULT_LATENCY = 3;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_REPLIES   = 4;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_CHARS   = 500;
    localparam int MIN_REPLIES    = 36;
    localparam logic [7:0] CR     = 8'h0D;
    localparam logic [7:0] LF     = 8'h0A;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         reply_char;
    logic               eor;
    logic               cfg_wr_en;
    logic [7:0]         cfg_wr_data;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic signed [22:0] value_q8;
    logic [7:0]         data_a;
    logic [7:0]         data_b;

    int         fail_count;
    int         pending;
    int         sender_idle_pct;
    int         receiver_idle_pct;
    int         hold_left;
    int         chars_sent;
    int         replies_sent;
    int         cycle_count = 0;
    bit         hold_go;
    bit         hold_done;
    logic [7:0] cur_pid;
    logic [7:0] reply_buf [$];

    obd_mode01_reply_decoder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_reply_char   (reply_char),
        .i_end_of_reply (eor),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_value_q8     (value_q8),
        .o_data_a       (data_a),
        .o_data_b       (data_b)
    );

    obd_mode01_reply_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_reply_char   (reply_char),
        .i_end_of_reply (eor),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_value_q8     (value_q8),
        .i_data_a       (data_a),
        .i_data_b       (data_b),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall, or one long hold-off when asked for.
    always @(negedge clk) begin
        if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) begin
            return "0" + {4'h0, n};
        end
        return (lower ? "a" : "A") + {4'h0, n} - 8'd10;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        reply_buf.push_back(hex_char(b[7:4], 1'($urandom_range(1))));
        reply_buf.push_back(hex_char(b[3:0], 1'($urandom_range(1))));
        case ($urandom_range(5))
            0, 1:    reply_buf.push_back(" ");
            2:       reply_buf.push_back(CR);
            default: ;
        endcase
    endtask

    // Characters that are neither hex digits nor NUL.
    task automatic add_filler(input int n);
        string pool;
        pool = "STOPRMXz .:>";
        repeat (n) begin
            if ($urandom_range(5) == 0) begin
                reply_buf.push_back($urandom_range(1) ? CR : LF);
            end else begin
                reply_buf.push_back(8'(pool[$urandom_range(pool.len() - 1)]));
            end
        end
    endtask

    task automatic add_text(input string s, input int n);
        for (int i = 0; i < s.len() && i < n; i++) begin
            reply_buf.push_back(8'(s[i]));
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        reply_char <= c;
        eor        <= last;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        chars_sent++;
    endtask

    task automatic send_reply();
        for (int i = 0; i < reply_buf.size(); i++) begin
            send_char(reply_buf[i], i == reply_buf.size() - 1);
        end
        replies_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_pid(input logic [7:0] pid);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pid;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_pid = pid;
    endtask

    task automatic build_reply();
        int    roll;
        int    n;
        int    hdr_at;
        string word;
        reply_buf.delete();
        roll = $urandom_range(99);
        if (roll < 62) begin
            // Well-formed reply with optional echo bytes, junk and a trailing NUL.
            if ($urandom_range(99) < 30) add_filler($urandom_range(1, 4));
            if ($urandom_range(99) < 35) begin
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 8) begin
                reply_buf.push_back(hex_char(4'($urandom_range(15)), 1'b0));
            end
            add_byte(MODE01_REPLY);
            add_byte(($urandom_range(99) < 85) ? cur_pid : 8'($urandom_range(255)));
            n = $urandom_range(99);
            n = (n < 10) ? 0 : (n < 25) ? 1 : (n < 85) ? 2 : 3;
            repeat (n) add_byte(8'($urandom_range(255)));
            if ($urandom_range(99) < 10) begin
                add_byte(MODE01_REPLY);
                add_byte(cur_pid);
                add_byte(8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 15) begin
                reply_buf.push_back(CHAR_NUL);
                repeat ($urandom_range(1, 3)) reply_buf.push_back(8'($urandom_range(255)));
            end else if ($urandom_range(99) < 20) begin
                add_filler($urandom_range(1, 2));
            end
        end else if (roll < 72) begin
            case ($urandom_range(3))
                0:       word = "NO DATA";
                1:       word = "CAN ERROR";
                2:       word = "UNABLE";
                default: word = "BUS ERROR";
            endcase
            if ($urandom_range(99) < 30) add_filler($urandom_range(1, 3));
            if ($urandom_range(99) < 25) add_text(word, 2);
            add_text(word, ($urandom_range(99) < 80) ? word.len() : word.len() - 1);
            if ($urandom_range(1)) add_byte(8'($urandom_range(255)));
        end else if (roll < 78) begin
            if ($urandom_range(1)) add_filler($urandom_range(1, 3));
            reply_buf.push_back(CHAR_QMARK);
            if ($urandom_range(1)) add_filler($urandom_range(1, 2));
        end else if (roll < 84) begin
            reply_buf.push_back(CHAR_NUL);
            if ($urandom_range(1)) begin
                repeat ($urandom_range(1, 3)) reply_buf.push_back(8'($urandom_range(255)));
            end
        end else if (roll < 87) begin
            // Long reply that runs into the byte limit; the header may fall past it.
            n      = $urandom_range(60, 70);
            hdr_at = $urandom_range(n);
            for (int i = 0; i <= n; i++) begin
                if (i == hdr_at) begin
                    add_byte(MODE01_REPLY);
                    add_byte(cur_pid);
                    add_byte(8'($urandom_range(255)));
                    add_byte(8'($urandom_range(255)));
                end else begin
                    add_byte(8'($urandom_range(255)));
                end
            end
        end else begin
            repeat ($urandom_range(1, 8)) reply_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int start_chars;
        int start_replies;
        int hold_start;
        clk               = 1'b0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        reply_char        = 8'd0;
        eor               = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = 8'd0;
        out_stall         = 1'b0;
        hold_go           = 1'b0;
        hold_done         = 1'b0;
        hold_left         = 0;
        chars_sent        = 0;
        replies_sent      = 0;
        cur_pid           = PID_RESET;
        sender_idle_pct   = 32;
        receiver_idle_pct = 57;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed replies under the reset PID, then the lowest coolant value.
        reply_buf = {CHAR_NUL};
        send_reply();
        reply_buf = {CHAR_QMARK};
        send_reply();
        reply_buf.delete();
        add_text("410CFFFF", 8);
        send_reply();
        reply_buf.delete();
        add_text("410C0", 5);
        send_reply();
        reply_buf = {8'h34, CHAR_NUL, 8'h78};
        send_reply();
        write_pid(PID_COOLANT);
        reply_buf.delete();
        add_text("410500", 6);
        send_reply();

        start_chars   = chars_sent;
        start_replies = replies_sent;
        hold_start    = 0;
        while (chars_sent - start_chars < RANDOM_CHARS ||
               replies_sent - start_replies < MIN_REPLIES ||
               !hold_done || replies_sent - hold_start < HOLD_REPLIES) begin
            if (chars_sent - start_chars < 170) begin
                sender_idle_pct   = 32;
                receiver_idle_pct = 57;
            end else if (chars_sent - start_chars < 340) begin
                sender_idle_pct   = 57;
                receiver_idle_pct = 32;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
                if (!hold_done) begin
                    hold_go    = 1'b1;
                    hold_done  = 1'b1;
                    hold_start = replies_sent;
                end
            end
            // Register writes pause during the long hold-off, so that replies
            // keep coming until the block fills up and stalls its input.
            if ((replies_sent - start_replies) % 3 == 0 && !hold_go && hold_left == 0) begin
                case (((replies_sent - start_replies) / 3) % 12)
                    0:       write_pid(PID_MAF);
                    1:       write_pid(PID_SPEED);
                    2:       write_pid(PID_MAP);
                    3:       write_pid(PID_COOLANT);
                    4:       write_pid(PID_IAT);
                    5:       write_pid(PID_THROTTLE);
                    6:       write_pid(PID_FUEL);
                    7:       write_pid(8'h00);
                    8:       write_pid(8'hFF);
                    9:       write_pid(PID_RPM);
                    10:      write_pid(MODE01_REPLY);
                    default: write_pid(8'($urandom_range(255)));
                endcase
            end
            build_reply();
            send_reply();
        end

        wait_idle();
        repeat (RESULT_LATENCY * 4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== obd_mode01_reply_decoder.f =====
rtl/omrd_pkg.sv
rtl/omrd_scan.sv
rtl/omrd_decode.sv
rtl/obd_mode01_reply_decoder.sv
bench/obd_mode01_reply_checker.sv
bench/tb_obd_mode01_reply_decoder.sv
